// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper: shared package
// Status codes, queue sizing and the command word that the parser hands to
// the UTF-8 encoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Depth of the command queue between parser and encoder. Eight entries
    // cover the backlog of a four-byte code point followed by plain bytes.
    localparam int CmdDepth = 8;
    localparam int PtrW     = $clog2(CmdDepth);
    localparam int CntW     = $clog2(CmdDepth + 1);

    // Result status codes.
    localparam logic [3:0] ST_DATA      = 4'd0;
    localparam logic [3:0] ST_CLOSED    = 4'd1;
    localparam logic [3:0] ST_NO_OPEN   = 4'd2;
    localparam logic [3:0] ST_CTRL      = 4'd3;
    localparam logic [3:0] ST_BAD_ESC   = 4'd4;
    localparam logic [3:0] ST_BAD_HEX   = 4'd5;
    localparam logic [3:0] ST_NO_LOW    = 4'd6;
    localparam logic [3:0] ST_BAD_LOW   = 4'd7;
    localparam logic [3:0] ST_STRAY_LOW = 4'd8;
    localparam logic [3:0] ST_UNTERM    = 4'd9;
    localparam logic [3:0] ST_END_BS    = 4'd10;
    localparam logic [3:0] ST_SHORT_U   = 4'd11;

    // One parser command: a status result, a raw byte, or a code point.
    typedef struct packed {
        logic [3:0]  status;  // not ST_DATA: a single status result
        logic        raw;     // pass cp[7:0] through as one byte
        logic [20:0] cp;      // code point to encode as UTF-8
    } t_cmd;

    // Head of the command queue as seen by the encoder.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

endpackage

// ===== rtl/jsu_front.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper: parser front end
// Walks the string one input byte per cycle while bytes are taken, decodes escapes and surrogate
// pairs, and issues at most one command per byte into the queue.
// ----------------------------------------------------------------------------
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_in_byte,
    input  logic          i_end_of_input,
    output logic          o_cmd_valid,
    output jsu_pkg::t_cmd o_cmd
);

    // Parser phases.
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_STR     = 4'd1;
    localparam logic [3:0] PH_ESC     = 4'd2;
    localparam logic [3:0] PH_HEX1    = 4'd3;
    localparam logic [3:0] PH_PAIR_BS = 4'd4;
    localparam logic [3:0] PH_PAIR_U  = 4'd5;
    localparam logic [3:0] PH_HEX2    = 4'd6;

    // Hex digit value, with bit 4 set for a byte that is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [7:0] t;
        begin
            t = 8'h00;
            if (b >= 8'h30 && b <= 8'h39) begin
                t = b - 8'h30;
            end else if (b >= 8'h61 && b <= 8'h66) begin
                t = b - 8'h57;
            end else if (b >= 8'h41 && b <= 8'h46) begin
                t = b - 8'h37;
            end else begin
                t = 8'h10;
            end
            hex_value = t[4:0];
        end
    endfunction

    logic [3:0]  r_phase,     n_phase;
    logic [1:0]  r_hex_count, n_hex_count;
    logic [15:0] r_code_unit, n_code_unit;
    logic [9:0]  r_high_half, n_high_half;

    logic [4:0]  w_digit;
    logic [15:0] w_unit;
    logic [10:0] w_plane;

    assign w_digit = hex_value(i_in_byte);
    assign w_unit  = {r_code_unit[11:0], w_digit[3:0]};
    assign w_plane = {1'b0, r_high_half} + 11'd64;

    // Next-state and command decode for one byte.
    always_comb begin
        n_phase     = r_phase;
        n_hex_count = r_hex_count;
        n_code_unit = r_code_unit;
        n_high_half = r_high_half;
        o_cmd_valid = 1'b0;
        o_cmd       = '0;

        unique case (r_phase)
            PH_STR: begin
                if (i_end_of_input) begin
                    n_phase = PH_IDLE; o_cmd_valid = 1'b1; o_cmd.status = jsu_pkg::ST_UNTERM;
                end else if (i_in_byte == 8'h22) begin
                    n_phase = PH_IDLE; o_cmd_valid = 1'b1; o_cmd.status = jsu_pkg::ST_CLOSED;
                end else if (i_in_byte < 8'h20) begin
                    n_phase = PH_IDLE; o_cmd_valid = 1'b1; o_cmd.status = jsu_pkg::ST_CTRL;
                end else if (i_in_byte == 8'h5C) begin
                    n_phase = PH_ESC;
                end else begin
                    o_cmd_valid = 1'b1;
                    o_cmd.raw   = 1'b1;
                    o_cmd.cp    = {13'd0, i_in_byte};
                end
            end
            PH_ESC: begin
                if (i_end_of_input) begin
                    n_phase = PH_IDLE; o_cmd_valid = 1'b1; o_cmd.status = jsu_pkg::ST_END_BS;
                end else begin
                    n_phase     = PH_STR;
                    o_cmd_valid = 1'b1;
                    o_cmd.raw   = 1'b1;
                    unique case (i_in_byte)
                        8'h22, 8'h5C, 8'h2F: o_cmd.cp = {13'd0, i_in_byte};
                        8'h62: o_cmd.cp = 21'h08;
                        8'h66: o_cmd.cp = 21'h0C;
                        8'h6E: o_cmd.cp = 21'h0A;
                        8'h72: o_cmd.cp = 21'h0D;
                        8'h74: o_cmd.cp = 21'h09;
                        8'h75: begin
                            n_phase     = PH_HEX1;
                            n_hex_count = 2'd0;
                            n_code_unit = 16'd0;
                            o_cmd_valid = 1'b0;
                        end
                        default: begin
                            n_phase      = PH_IDLE;
                            o_cmd.raw    = 1'b0;
                            o_cmd.status = jsu_pkg::ST_BAD_ESC;
                        end
                    endcase
                end
            end
            PH_HEX1, PH_HEX2: begin
                if (i_end_of_input) begin
                    n_phase = PH_IDLE; o_cmd_valid = 1'b1; o_cmd.status = jsu_pkg::ST_SHORT_U;
                end else if (w_digit[4]) begin
                    n_phase = PH_IDLE; o_cmd_valid = 1'b1; o_cmd.status = jsu_pkg::ST_BAD_HEX;
                end else begin
                    n_code_unit = w_unit;
                    if (r_hex_count != 2'd3) begin
                        n_hex_count = r_hex_count + 2'd1;
                    end else begin
                        n_hex_count = 2'd0;
                        if (r_phase == PH_HEX1) begin
                            // First unit: high surrogate waits for its partner.
                            if (w_unit[15:10] == 6'b110110) begin
                                n_high_half = w_unit[9:0];
                                n_phase     = PH_PAIR_BS;
                            end else if (w_unit[15:10] == 6'b110111) begin
                                n_phase      = PH_IDLE;
                                o_cmd_valid  = 1'b1;
                                o_cmd.status = jsu_pkg::ST_STRAY_LOW;
                            end else begin
                                n_phase     = PH_STR;
                                o_cmd_valid = 1'b1;
                                o_cmd.cp    = {5'd0, w_unit};
                            end
                        end else begin
                            // Second unit must be a low surrogate.
                            o_cmd_valid = 1'b1;
                            if (w_unit[15:10] != 6'b110111) begin
                                n_phase      = PH_IDLE;
                                o_cmd.status = jsu_pkg::ST_BAD_LOW;
                            end else begin
                                n_phase  = PH_STR;
                                o_cmd.cp = {w_plane[10:0], w_unit[9:0]};
                            end
                        end
                    end
                end
            end
            PH_PAIR_BS: begin
                if (i_end_of_input || i_in_byte != 8'h5C) begin
                    n_phase = PH_IDLE; o_cmd_valid = 1'b1; o_cmd.status = jsu_pkg::ST_NO_LOW;
                end else begin
                    n_phase = PH_PAIR_U;
                end
            end
            PH_PAIR_U: begin
                if (i_end_of_input || i_in_byte != 8'h75) begin
                    n_phase = PH_IDLE; o_cmd_valid = 1'b1; o_cmd.status = jsu_pkg::ST_NO_LOW;
                end else begin
                    n_phase     = PH_HEX2;
                    n_hex_count = 2'd0;
                    n_code_unit = 16'd0;
                end
            end
            default: begin
                // Idle, and any unused phase code, waits for an opening quote.
                n_phase = PH_IDLE;
                if (!i_end_of_input) begin
                    if (i_in_byte == 8'h22) begin
                        n_phase = PH_STR;
                    end else begin
                        o_cmd_valid  = 1'b1;
                        o_cmd.status = jsu_pkg::ST_NO_OPEN;
                    end
                end
            end
        endcase
    end

    // Parser state advances only on an accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_hex_count <= 2'd0;
            r_code_unit <= 16'd0;
            r_high_half <= 10'd0;
        end else if (i_take) begin
            r_phase     <= n_phase;
            r_hex_count <= n_hex_count;
            r_code_unit <= n_code_unit;
            r_high_half <= n_high_half;
        end
    end

endmodule

// ===== rtl/jsu_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper: command queue
// Short queue of parser commands that decouples the parser from the encoder.
// ----------------------------------------------------------------------------
module jsu_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  jsu_pkg::t_cmd i_cmd,
    input  logic          i_rd,
    output jsu_pkg::t_head o_head,
    output logic          o_full
);

    jsu_pkg::t_cmd r_mem [jsu_pkg::CmdDepth];

    logic [jsu_pkg::PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [jsu_pkg::CntW-1:0] r_count;

    assign o_full       = (r_count == jsu_pkg::CntW'(jsu_pkg::CmdDepth));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + jsu_pkg::PtrW'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + jsu_pkg::PtrW'(1);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + jsu_pkg::CntW'(1);
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - jsu_pkg::CntW'(1);
            end
        end
    end

endmodule

// ===== rtl/jsu_back.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper: UTF-8 back end
// Takes queued commands and, while its output register is free or drains, emits
// one result word per cycle into it: status words, raw bytes, or UTF-8 bytes.
// ----------------------------------------------------------------------------
module jsu_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  jsu_pkg::t_head i_head,
    output logic           o_fetch,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [3:0]     o_status,
    output logic [7:0]     o_out_byte,
    output logic           o_last
);

    jsu_pkg::t_cmd r_cmd;
    logic          r_cmd_valid;
    logic [1:0]    r_idx;
    logic          r_out_valid;
    logic [3:0]    r_status;
    logic [7:0]    r_byte;
    logic          r_last;

    logic [7:0] w_bytes [4];
    logic [1:0] w_last_idx;
    logic       w_adv;
    logic       w_done;

    // UTF-8 byte lanes and length of the current command.
    always_comb begin
        w_bytes[0] = 8'h00;
        w_bytes[1] = 8'h00;
        w_bytes[2] = 8'h00;
        w_bytes[3] = 8'h00;
        w_last_idx = 2'd0;
        if (r_cmd.status != jsu_pkg::ST_DATA) begin
            w_last_idx = 2'd0;
        end else if (r_cmd.raw || r_cmd.cp[20:7] == '0) begin
            w_bytes[0] = r_cmd.cp[7:0];
        end else if (r_cmd.cp[20:11] == '0) begin
            w_last_idx = 2'd1;
            w_bytes[0] = {3'b110, r_cmd.cp[10:6]};
            w_bytes[1] = {2'b10, r_cmd.cp[5:0]};
        end else if (r_cmd.cp[20:16] == '0) begin
            w_last_idx = 2'd2;
            w_bytes[0] = {4'b1110, r_cmd.cp[15:12]};
            w_bytes[1] = {2'b10, r_cmd.cp[11:6]};
            w_bytes[2] = {2'b10, r_cmd.cp[5:0]};
        end else begin
            w_last_idx = 2'd3;
            w_bytes[0] = {5'b11110, r_cmd.cp[20:18]};
            w_bytes[1] = {2'b10, r_cmd.cp[17:12]};
            w_bytes[2] = {2'b10, r_cmd.cp[11:6]};
            w_bytes[3] = {2'b10, r_cmd.cp[5:0]};
        end
    end

    // A word moves to the output register when that register is free or drains.
    assign w_adv   = r_cmd_valid && (!r_out_valid || i_pop);
    assign w_done  = w_adv && (r_idx == w_last_idx);
    assign o_fetch = i_head.valid && (!r_cmd_valid || w_done);

    // Current command and byte index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else if (o_fetch) begin
            r_cmd_valid <= 1'b1;
            r_idx       <= 2'd0;
        end else if (w_done) begin
            r_cmd_valid <= 1'b0;
        end else if (w_adv) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fetch) begin
            r_cmd <= i_head.cmd;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_status <= r_cmd.status;
            r_byte   <= w_bytes[r_idx];
            r_last   <= (r_idx == w_last_idx);
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_status   = r_status;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;

endmodule

// ===== rtl/json_string_unescape_utf8_top.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper, top level
// Decodes a JSON string token byte by byte into UTF-8 bytes and status words.
//
//   Channel   Handshake      Word fields
//   input     push / full    i_in_byte[7:0], i_end_of_input
//   result    pop / empty    o_status[3:0], o_out_byte[7:0], o_last
//
// One input byte is taken per cycle while push is high and full is low; result
// words leave one per cycle while pop is held and a word is waiting.
// The encoder emits one to four words per command, but a multi-byte code
// point needs a six- or twelve-byte escape, so the encoder keeps pace with one
// input byte per cycle; the eight-entry command queue absorbs the bursts.
// Reset is synchronous and clears the parser, queue and output register.
// full rises only while the command queue is full; pop may stall at will.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       empty,
    input  logic       pop,
    output logic [3:0] o_status,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    logic           w_take;
    logic           w_cmd_valid;
    jsu_pkg::t_cmd  w_cmd;
    jsu_pkg::t_head w_head;
    logic           w_fetch;

    assign w_take = push && !full;

    // Parser.
    jsu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (w_take),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd          (w_cmd)
    );

    // Command queue.
    jsu_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_take && w_cmd_valid),
        .i_cmd   (w_cmd),
        .i_rd    (w_fetch),
        .o_head  (w_head),
        .o_full  (full)
    );

    // UTF-8 encoder and output register.
    jsu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_fetch    (w_fetch),
        .i_pop      (pop && !empty),
        .o_empty    (empty),
        .o_status   (o_status),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule

// ===== rtl/jsu_checker.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper: port checker
// Watches the top-level ports for result words that break the block's rules.
// ----------------------------------------------------------------------------
module jsu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [3:0] o_status,
    input logic [7:0] o_out_byte,
    input logic       o_last
);

    // A status word carries no byte and always ends its input's results.
    a_status_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != jsu_pkg::ST_DATA) |-> (o_out_byte == 8'h00 && o_last))
        else $error("status word with data byte or without last");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status <= jsu_pkg::ST_SHORT_U))
        else $error("undefined status code");

    // Reset leaves no result and room for input.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("result or full after reset");

    // A waiting word holds while it is not taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_out_byte)
                              && $stable(o_last)))
        else $error("waiting result changed");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (.*);

// ===== bench/json_string_unescape_utf8_checker.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper: result checker
// Watches the input and result queues of the unescaper. It predicts the
// result words of each accepted input word from its own copy of the decoder
// state, then compares each popped result word with the oldest prediction.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    input  logic       empty,
    input  logic       pop,
    input  logic [3:0] i_status,
    input  logic [7:0] i_out_byte,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Characters that steer the decoder.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef enum logic [3:0] {
        WAIT_QUOTE,
        IN_STRING,
        AFTER_BSLASH,
        LEAD_HEX,
        TRAIL_BSLASH,
        TRAIL_U,
        TRAIL_HEX
    } t_decode_phase;

    typedef struct packed {
        logic [3:0] status;
        logic [7:0] data;
        logic       last;
    } t_decoded_word;

    // Decoder state as predicted.
    t_decode_phase phase;
    logic [1:0]    digit_idx;
    logic [15:0]   code_unit;
    logic [9:0]    high_bits;

    t_decoded_word step_words[$];
    t_decoded_word predicted_words[$];
    int            mismatches    = 0;
    int            words_checked = 0;

    // Returns the digit value, or 16 when the character is not a hex digit.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
        if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
        return 5'd16;
    endfunction

    task automatic add_word(input logic [3:0] status, input logic [7:0] data);
        t_decoded_word w;
        w = '{status: status, data: data, last: 1'b0};
        step_words = {step_words, w};
    endtask

    // Any status other than data ends the string.
    task automatic abort_string(input logic [3:0] status);
        phase = WAIT_QUOTE;
        add_word(status, 8'h00);
    endtask

    task automatic encode_utf8(input logic [20:0] cp);
        if (cp <= 21'h7F) begin
            add_word(jsu_pkg::ST_DATA, cp[7:0]);
        end else if (cp <= 21'h7FF) begin
            add_word(jsu_pkg::ST_DATA, {3'b110, cp[10:6]});
            add_word(jsu_pkg::ST_DATA, {2'b10, cp[5:0]});
        end else if (cp <= 21'hFFFF) begin
            add_word(jsu_pkg::ST_DATA, {4'b1110, cp[15:12]});
            add_word(jsu_pkg::ST_DATA, {2'b10, cp[11:6]});
            add_word(jsu_pkg::ST_DATA, {2'b10, cp[5:0]});
        end else begin
            add_word(jsu_pkg::ST_DATA, {5'b11110, cp[20:18]});
            add_word(jsu_pkg::ST_DATA, {2'b10, cp[17:12]});
            add_word(jsu_pkg::ST_DATA, {2'b10, cp[11:6]});
            add_word(jsu_pkg::ST_DATA, {2'b10, cp[5:0]});
        end
    endtask

    // Shifts in one hex digit; done rises with the fourth digit.
    task automatic take_digit(input logic [7:0] c, output logic done);
        logic [4:0] nib;
        nib  = hex_nibble(c);
        done = 1'b0;
        if (nib[4]) begin
            abort_string(jsu_pkg::ST_BAD_HEX);
        end else begin
            code_unit = {code_unit[11:0], nib[3:0]};
            if (digit_idx == 2'd3) begin
                digit_idx = 2'd0;
                done      = 1'b1;
            end else begin
                digit_idx = digit_idx + 2'd1;
            end
        end
    endtask

    // Predicts the result words of one input word and queues them.
    task automatic predict_step(input logic [7:0] c, input logic eoi);
        logic done;
        step_words.delete();
        case (phase)
            IN_STRING: begin
                if (eoi) abort_string(jsu_pkg::ST_UNTERM);
                else if (c == CH_QUOTE) abort_string(jsu_pkg::ST_CLOSED);
                else if (c < 8'h20) abort_string(jsu_pkg::ST_CTRL);
                else if (c == CH_BSLASH) phase = AFTER_BSLASH;
                else add_word(jsu_pkg::ST_DATA, c);
            end
            AFTER_BSLASH: begin
                if (eoi) begin
                    abort_string(jsu_pkg::ST_END_BS);
                end else begin
                    phase = IN_STRING;
                    case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: add_word(jsu_pkg::ST_DATA, c);
                        CH_B: add_word(jsu_pkg::ST_DATA, 8'h08);
                        CH_F: add_word(jsu_pkg::ST_DATA, 8'h0C);
                        CH_N: add_word(jsu_pkg::ST_DATA, 8'h0A);
                        CH_R: add_word(jsu_pkg::ST_DATA, 8'h0D);
                        CH_T: add_word(jsu_pkg::ST_DATA, 8'h09);
                        CH_U: begin
                            phase     = LEAD_HEX;
                            digit_idx = 2'd0;
                            code_unit = 16'h0000;
                        end
                        default: abort_string(jsu_pkg::ST_BAD_ESC);
                    endcase
                end
            end
            LEAD_HEX: begin
                if (eoi) begin
                    abort_string(jsu_pkg::ST_SHORT_U);
                end else begin
                    take_digit(c, done);
                    if (done) begin
                        if (code_unit >= 16'hD800 && code_unit <= 16'hDBFF) begin
                            high_bits = code_unit[9:0];
                            phase     = TRAIL_BSLASH;
                        end else if (code_unit >= 16'hDC00 && code_unit <= 16'hDFFF) begin
                            abort_string(jsu_pkg::ST_STRAY_LOW);
                        end else begin
                            phase = IN_STRING;
                            encode_utf8({5'd0, code_unit});
                        end
                    end
                end
            end
            TRAIL_BSLASH: begin
                if (eoi || c != CH_BSLASH) abort_string(jsu_pkg::ST_NO_LOW);
                else phase = TRAIL_U;
            end
            TRAIL_U: begin
                if (eoi || c != CH_U) begin
                    abort_string(jsu_pkg::ST_NO_LOW);
                end else begin
                    phase     = TRAIL_HEX;
                    digit_idx = 2'd0;
                    code_unit = 16'h0000;
                end
            end
            TRAIL_HEX: begin
                if (eoi) begin
                    abort_string(jsu_pkg::ST_SHORT_U);
                end else begin
                    take_digit(c, done);
                    if (done) begin
                        if (code_unit < 16'hDC00 || code_unit > 16'hDFFF) begin
                            abort_string(jsu_pkg::ST_BAD_LOW);
                        end else begin
                            phase = IN_STRING;
                            encode_utf8(21'h10000 + {1'b0, high_bits, code_unit[9:0]});
                        end
                    end
                end
            end
            default: begin
                phase = WAIT_QUOTE;
                if (!eoi) begin
                    if (c == CH_QUOTE) phase = IN_STRING;
                    else add_word(jsu_pkg::ST_NO_OPEN, 8'h00);
                end
            end
        endcase
        // The final word of the step carries the last flag.
        if (step_words.size() > 0) begin
            step_words[step_words.size() - 1].last = 1'b1;
        end
        predicted_words = {predicted_words, step_words};
    endtask

    task automatic log_failure(input logic had_prediction, input t_decoded_word want,
                               input t_decoded_word got);
        mismatches++;
        if (mismatches <= 10) begin
            if (had_prediction) begin
                $display("Mismatch on word %0d (exp/got): status %0d/%0d byte %02h/%02h",
                         words_checked, want.status, got.status, want.data, got.data);
                $display("    last %0b/%0b", want.last, got.last);
            end else begin
                $display("Unpredicted result word %0d: status %0d byte %02h last %0b",
                         words_checked, got.status, got.data, got.last);
            end
        end
    endtask

    // Prediction on each accepted input word, comparison on each popped result.
    always @(posedge i_clk) begin
        t_decoded_word got;
        t_decoded_word want;
        if (!i_rst_n) begin
            phase     = WAIT_QUOTE;
            digit_idx = 2'd0;
            code_unit = 16'h0000;
            high_bits = 10'd0;
            predicted_words.delete();
        end else begin
            if (push && !full) predict_step(i_in_byte, i_end_of_input);
            if (pop && !empty) begin
                got = '{status: i_status, data: i_out_byte, last: i_last};
                if (predicted_words.size() == 0) begin
                    want = '0;
                    log_failure(1'b0, want, got);
                end else begin
                    want = predicted_words.pop_front();
                    if (got.status !== want.status || got.data !== want.data ||
                        got.last !== want.last) begin
                        log_failure(1'b1, want, got);
                    end
                end
                words_checked++;
            end
        end
        o_pending       <= predicted_words.size();
        o_fail_count    <= mismatches;
        o_words_checked <= words_checked;
    end

endmodule

// ===== bench/json_string_unescape_utf8_top_tb.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper testbench
// Feeds the unescaper directed and random JSON string tokens: plain and raw
// bytes, all simple escapes, \u escapes of every UTF-8 length, surrogate
// pairs and every error ending. Both queues stall at random. A separate
// checker predicts and compares the result words; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LimitCycles = 200000;
    localparam int TargetWords = 220;
    localparam int NumErrKinds = 14;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       push           = 1'b0;
    logic       pop            = 1'b0;
    logic [7:0] i_in_byte      = 8'h00;
    logic       i_end_of_input = 1'b0;
    logic       full;
    logic       empty;
    logic [3:0] o_status;
    logic [7:0] o_out_byte;
    logic       o_last;

    int fail_count;
    int pending;
    int words_checked;
    bit calm = 1'b0;
    int words_sent = 0;
    int strings_sent = 0;
    int watchdog_cycles = 0;

    json_string_unescape_utf8_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .empty          (empty),
        .pop            (pop),
        .o_status       (o_status),
        .o_out_byte     (o_out_byte),
        .o_last         (o_last)
    );

    json_string_unescape_utf8_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_in_byte       (i_in_byte),
        .i_end_of_input  (i_end_of_input),
        .empty           (empty),
        .pop             (pop),
        .i_status        (o_status),
        .i_out_byte      (o_out_byte),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: pop stalls now and then, except in the calm stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) pop <= 1'b0;
        else pop <= calm || ($urandom_range(0, 99) >= 6);
    end

    // Watchdog.
    initial begin
        while (watchdog_cycles < LimitCycles) begin
            @(posedge i_clk);
            watchdog_cycles++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding",
                 watchdog_cycles, pending);
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    // Hex digit character, letters in either case.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        if ($urandom_range(0, 1)) return 8'h61 + 8'(n) - 8'd10;
        return 8'h41 + 8'(n) - 8'd10;
    endfunction

    // Offers one word and holds it until the unescaper takes it.
    task automatic send_word(input logic [7:0] c, input logic eoi);
        if (!calm && $urandom_range(0, 99) < 6) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_in_byte      <= c;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (full);
        words_sent++;
    endtask

    task automatic send_byte(input logic [7:0] c);
        send_word(c, 1'b0);
    endtask

    // End of input; the byte lane carries junk.
    task automatic send_eoi();
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_u_escape(input logic [15:0] v);
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        for (int i = 3; i >= 0; i--) send_byte(hex_char(v[4*i +: 4]));
    endtask

    // Backslash, u and fewer than four hex digits.
    task automatic send_partial_u();
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        repeat ($urandom_range(0, 3)) send_byte(hex_char(4'($urandom_range(0, 15))));
    endtask

    task automatic send_high_half();
        send_u_escape(16'hD800 + 16'($urandom_range(0, 1023)));
    endtask

    function automatic logic [7:0] pick_non_hex();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_hex(c));
        return c;
    endfunction

    // String body segment: plain byte, simple escape, BMP escape or pair.
    task automatic send_segment();
        logic [7:0]  c;
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                do c = 8'($urandom_range(8'h20, 8'hFF));
                while (c == CH_QUOTE || c == CH_BSLASH);
                send_byte(c);
            end
            4, 5: begin
                send_byte(CH_BSLASH);
                case ($urandom_range(0, 7))
                    0: send_byte(CH_QUOTE);
                    1: send_byte(CH_BSLASH);
                    2: send_byte(CH_SLASH);
                    3: send_byte(CH_B);
                    4: send_byte(CH_F);
                    5: send_byte(CH_N);
                    6: send_byte(CH_R);
                    default: send_byte(CH_T);
                endcase
            end
            6, 7: begin
                case ($urandom_range(0, 3))
                    0: v = 16'($urandom_range(16'h0000, 16'h007F));
                    1: v = 16'($urandom_range(16'h0080, 16'h07FF));
                    2: v = 16'($urandom_range(16'h0800, 16'hD7FF));
                    default: v = 16'($urandom_range(16'hE000, 16'hFFFF));
                endcase
                send_u_escape(v);
            end
            default: begin
                send_high_half();
                send_u_escape(16'hDC00 + 16'($urandom_range(0, 1023)));
            end
        endcase
    endtask

    // One token: opening quote, a body, then a close or one error ending.
    task automatic send_string(input logic well_formed, input int err_kind);
        logic [7:0]  c;
        logic [15:0] v;
        send_byte(CH_QUOTE);
        repeat ($urandom_range(0, 1)) send_segment();
        if (well_formed) begin
            send_byte(CH_QUOTE);
        end else begin
            case (err_kind)
                0: send_byte(8'($urandom_range(0, 8'h1F)));
                1: begin
                    send_byte(CH_BSLASH);
                    do c = 8'($urandom_range(0, 255));
                    while (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_B ||
                           c == CH_F || c == CH_N || c == CH_R || c == CH_T || c == CH_U);
                    send_byte(c);
                end
                2: begin
                    send_partial_u();
                    send_byte(pick_non_hex());
                end
                3: begin
                    send_high_half();
                    do c = 8'($urandom_range(0, 255)); while (c == CH_BSLASH);
                    send_byte(c);
                end
                4: begin
                    send_high_half();
                    send_byte(CH_BSLASH);
                    do c = 8'($urandom_range(0, 255)); while (c == CH_U);
                    send_byte(c);
                end
                5: begin
                    send_high_half();
                    send_eoi();
                end
                6: begin
                    send_high_half();
                    send_byte(CH_BSLASH);
                    send_eoi();
                end
                7: begin
                    send_high_half();
                    do v = 16'($urandom); while (v >= 16'hDC00 && v <= 16'hDFFF);
                    send_u_escape(v);
                end
                8: send_u_escape(16'hDC00 + 16'($urandom_range(0, 1023)));
                9: send_eoi();
                10: begin
                    send_byte(CH_BSLASH);
                    send_eoi();
                end
                11: begin
                    send_partial_u();
                    send_eoi();
                end
                12: begin
                    send_high_half();
                    send_partial_u();
                    send_byte(pick_non_hex());
                end
                default: begin
                    send_high_half();
                    send_partial_u();
                    send_eoi();
                end
            endcase
        end
        strings_sent++;
    endtask

    // Stimulus and verdict.
    initial begin
        int         err_kind;
        int         idx;
        logic [7:0] c;
        err_kind = 0;
        idx      = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: junk and end while idle, byte extremes, \u0000, U+10FFFF.
        send_byte(8'h00);
        send_eoi();
        send_byte(CH_QUOTE);
        send_byte(8'h20);
        send_byte(8'hFF);
        send_u_escape(16'h0000);
        send_u_escape(16'hDBFF);
        send_u_escape(16'hDFFF);
        send_byte(CH_QUOTE);
        strings_sent++;

        // Random tokens, every other one ending in the next error kind.
        while (words_sent < TargetWords || err_kind < NumErrKinds) begin
            if (idx == 6) begin
                push <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            if (idx == 10) calm <= 1'b1;
            if (idx == 17) calm <= 1'b0;
            if (idx % 2) begin
                send_string(1'b0, err_kind % NumErrKinds);
                err_kind++;
            end else begin
                send_string(1'b1, 0);
            end
            // Noise between tokens.
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 2)) begin
                    if ($urandom_range(0, 1)) begin
                        send_eoi();
                    end else begin
                        do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
                        send_byte(c);
                    end
                end
            end
            idx++;
        end

        // Drain.
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (16) @(posedge i_clk);

        $display("Sent %0d input words in %0d tokens, checked %0d result words;",
                 words_sent, strings_sent, words_checked);
        $display("all escapes, UTF-8 lengths, surrogate pairs and error endings were driven.");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
